### hdl/cigar_alignment_scoring_unit_assert.svh
// Assertion macros for the alignment scoring unit.
// Used by the modules under hdl that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef CIGAR_ALIGNMENT_SCORING_UNIT_ASSERT_SVH
`define CIGAR_ALIGNMENT_SCORING_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition implies consequence in the same cycle
`define CAS_ASSERT_NOW(lbl, cond, conseq) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error("cas: same-cycle check failed");

// Condition implies consequence in the following cycle
`define CAS_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("cas: next-cycle check failed");

`else

`define CAS_ASSERT_NOW(lbl, cond, conseq)
`define CAS_ASSERT_NEXT(lbl, cond, conseq)

`endif

`endif

### hdl/cas_pkg.sv
// Shared types and constants for the alignment scoring unit.
// No dependencies; imported by every module of the block.
package cas_pkg;

    localparam int SCORE_W   = 48;
    localparam int RUN_W     = 21;
    localparam int LEN_W     = 22;
    localparam int CNT_W     = 21;
    localparam int GAP_W     = 22;
    localparam int CODE_W    = 4;
    localparam int PEN_W     = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int SUB_W     = 9;
    localparam int COST_W    = RUN_W + PEN_W;
    localparam int DELTA_W   = COST_W + 2;

    localparam int MAX_LEN_DEF = 1048576;
    localparam int RUN_MAX     = 2**RUN_W - 1;

    localparam logic [CODE_W-1:0] CODE_A = 4'd1;
    localparam logic [CODE_W-1:0] CODE_C = 4'd2;
    localparam logic [CODE_W-1:0] CODE_G = 4'd4;
    localparam logic [CODE_W-1:0] CODE_T = 4'd8;
    localparam logic [CODE_W-1:0] CODE_N = 4'd15;

    typedef enum logic [1:0] {
        OP_ALIGN = 2'd0,
        OP_INS   = 2'd1,
        OP_DEL   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATCH_SCORE    = 3'd0,
        REG_MISMATCH_SCORE = 3'd1,
        REG_N_IS_MISMATCH  = 3'd2,
        REG_QUERY_OPEN     = 3'd3,
        REG_TARGET_OPEN    = 3'd4,
        REG_QUERY_EXTEND   = 3'd5,
        REG_TARGET_EXTEND  = 3'd6
    } t_cfg_idx;

    localparam logic signed [SUB_W-1:0] MATCH_SCORE_RST    = 9'sd2;
    localparam logic signed [SUB_W-1:0] MISMATCH_SCORE_RST = -9'sd4;

    typedef struct packed {
        logic signed [SUB_W-1:0] match_score;
        logic signed [SUB_W-1:0] mismatch_score;
        logic                    n_is_mismatch;
        logic [CFG_W-1:0]        query_gap_open;
        logic [CFG_W-1:0]        target_gap_open;
        logic [CFG_W-1:0]        query_gap_extend;
        logic [CFG_W-1:0]        target_gap_extend;
    } t_cfg;

    // One scored item on its way to the accumulators
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [RUN_W-1:0]          len_inc;
        logic                      is_col;
        logic                      is_match;
        logic                      is_gap;
        logic                      last;
    } t_step;

endpackage

### hdl/cigar_alignment_scoring_unit.sv
// Top level of the alignment scoring unit: configuration registers, scoring stage, accumulators.
// Depends on cas_pkg, cas_delta and cas_accum.
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_stall    i_op, i_run_length, i_query_code,
//                                                  i_target_code, i_last_item
//   output   out        o_out_valid / i_out_stall  o_score, o_alignment_length, o_matches_res,
//                                                  o_mismatches, o_gaps
//   config   in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One word is taken per cycle while no closing word waits on a stalled result. A word is
// scored in the cycle it is taken (one 21x16 multiply for a gap run) and held in the
// stage register; from there it is added to the totals, and a closing word loads the
// result register and raises o_out_valid. Synchronous active-low reset clears the
// totals, the left-end flag and restores register defaults. A stalled result blocks a
// closing word; other words keep flowing into the totals until that word stalls the input.
module cigar_alignment_scoring_unit import cas_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic [RUN_W-1:0]          i_run_length,
    input  logic [CODE_W-1:0]         i_query_code,
    input  logic [CODE_W-1:0]         i_target_code,
    input  logic                      i_last_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [SCORE_W-1:0] o_score,
    output logic [LEN_W-1:0]          o_alignment_length,
    output logic [CNT_W-1:0]          o_matches_res,
    output logic [CNT_W-1:0]          o_mismatches,
    output logic [GAP_W-1:0]          o_gaps
);

    localparam t_cfg CFG_RST = '{
        match_score:       MATCH_SCORE_RST,
        mismatch_score:    MISMATCH_SCORE_RST,
        n_is_mismatch:     1'b0,
        query_gap_open:    '0,
        target_gap_open:   '0,
        query_gap_extend:  '0,
        target_gap_extend: '0
    };

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_step step;
    logic  step_valid;
    logic  take;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_MATCH_SCORE:    n_cfg.match_score       = i_cfg_data[SUB_W-1:0];
                REG_MISMATCH_SCORE: n_cfg.mismatch_score    = i_cfg_data[SUB_W-1:0];
                REG_N_IS_MISMATCH:  n_cfg.n_is_mismatch     = i_cfg_data[0];
                REG_QUERY_OPEN:     n_cfg.query_gap_open    = i_cfg_data;
                REG_TARGET_OPEN:    n_cfg.target_gap_open   = i_cfg_data;
                REG_QUERY_EXTEND:   n_cfg.query_gap_extend  = i_cfg_data;
                REG_TARGET_EXTEND:  n_cfg.target_gap_extend = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cas_delta #(
        .MAX_LEN (MAX_LEN)
    ) u_delta (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .i_take        (take),
        .i_op          (i_op),
        .i_run_length  (i_run_length),
        .i_query_code  (i_query_code),
        .i_target_code (i_target_code),
        .i_last_item   (i_last_item),
        .o_step        (step),
        .o_step_valid  (step_valid)
    );

    cas_accum u_accum (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_step_valid       (step_valid),
        .o_take             (take),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_score            (o_score),
        .o_alignment_length (o_alignment_length),
        .o_matches_res      (o_matches_res),
        .o_mismatches       (o_mismatches),
        .o_gaps             (o_gaps)
    );

    assign o_in_stall = !take;

endmodule

### hdl/cas_delta.sv
// Scoring stage: turns one edit-script word into a score change and count increments.
// Depends on cas_pkg; holds the left-end tracking flag and the stage register.
module cas_delta import cas_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic              i_take,
    input  logic [1:0]        i_op,
    input  logic [RUN_W-1:0]  i_run_length,
    input  logic [CODE_W-1:0] i_query_code,
    input  logic [CODE_W-1:0] i_target_code,
    input  logic              i_last_item,
    output t_step             o_step,
    output logic              o_step_valid
);

    localparam int unsigned CLAMP = (MAX_LEN > RUN_MAX) ? RUN_MAX : MAX_LEN;
    localparam logic [RUN_W-1:0] CLAMP_V = RUN_W'(CLAMP);

    function automatic logic unamb(input logic [CODE_W-1:0] c);
        return (c == CODE_A) || (c == CODE_C) || (c == CODE_G) || (c == CODE_T);
    endfunction

    logic                      r_at_start;
    logic                      n_at_start;
    logic                      r_step_valid;
    t_step                     r_step;
    t_step                     n_step;
    logic                      accept;
    logic [RUN_W-1:0]          run_c;
    logic                      nrule;
    logic [CFG_W-1:0]          go;
    logic [CFG_W-1:0]          ge;
    logic [PEN_W-1:0]          open_pen;
    logic [PEN_W-1:0]          ext_pen;
    logic [COST_W-1:0]         cost;
    logic signed [SUB_W-1:0]   sub;

    assign accept = i_valid && i_take;
    assign run_c  = (i_run_length > CLAMP_V) ? CLAMP_V : i_run_length;
    assign nrule  = i_cfg.n_is_mismatch && (i_query_code == CODE_N || i_target_code == CODE_N);

    // Left end wins over right end
    always_comb begin
        go = (t_op'(i_op) == OP_INS) ? i_cfg.query_gap_open : i_cfg.target_gap_open;
        ge = (t_op'(i_op) == OP_INS) ? i_cfg.query_gap_extend : i_cfg.target_gap_extend;
        if (r_at_start) begin
            open_pen = go[PEN_W-1:0];
            ext_pen  = ge[PEN_W-1:0];
        end else if (i_last_item) begin
            open_pen = go[2*PEN_W +: PEN_W];
            ext_pen  = ge[2*PEN_W +: PEN_W];
        end else begin
            open_pen = go[PEN_W +: PEN_W];
            ext_pen  = ge[PEN_W +: PEN_W];
        end
        cost = COST_W'(run_c) * COST_W'(ext_pen) + COST_W'(open_pen);
    end

    always_comb begin
        if (nrule) begin
            sub = i_cfg.mismatch_score;
        end else if (unamb(i_query_code) && unamb(i_target_code)) begin
            sub = (i_query_code == i_target_code) ? i_cfg.match_score : i_cfg.mismatch_score;
        end else begin
            sub = '0;
        end
    end

    always_comb begin
        n_step          = '0;
        n_step.last     = i_last_item;
        n_at_start      = r_at_start;
        case (t_op'(i_op))
            OP_ALIGN: begin
                n_step.delta    = DELTA_W'(sub);
                n_step.len_inc  = RUN_W'(1);
                n_step.is_col   = 1'b1;
                n_step.is_match = !nrule && ((i_query_code & i_target_code) != '0);
                n_at_start      = 1'b0;
            end
            OP_INS, OP_DEL: begin
                n_step.delta   = DELTA_W'(0) - $signed({2'b00, cost});
                n_step.len_inc = run_c;
                n_step.is_gap  = 1'b1;
                if (run_c != '0) begin
                    n_at_start = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // The alignment ends here: start afresh
        if (i_last_item) begin
            n_at_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_step_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_at_start <= n_at_start;
            end
            if (i_take) begin
                r_step_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step <= n_step;
        end
    end

    assign o_step       = r_step;
    assign o_step_valid = r_step_valid;

endmodule

### hdl/cas_accum.sv
// Accumulators and result register of the alignment scoring unit.
// Depends on cas_pkg and the assertion macro header.
`include "cigar_alignment_scoring_unit_assert.svh"

module cas_accum import cas_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_step                     i_step,
    input  logic                      i_step_valid,
    output logic                      o_take,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [SCORE_W-1:0] o_score,
    output logic [LEN_W-1:0]          o_alignment_length,
    output logic [CNT_W-1:0]          o_matches_res,
    output logic [CNT_W-1:0]          o_mismatches,
    output logic [GAP_W-1:0]          o_gaps
);

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    logic signed [SCORE_W-1:0] r_score;
    logic signed [SCORE_W-1:0] n_score;
    logic [LEN_W-1:0]          r_len;
    logic [LEN_W-1:0]          n_len;
    logic [CNT_W-1:0]          r_match;
    logic [CNT_W-1:0]          n_match;
    logic [CNT_W-1:0]          r_mism;
    logic [CNT_W-1:0]          n_mism;
    logic [GAP_W-1:0]          r_gap;
    logic [GAP_W-1:0]          n_gap;
    logic                      r_out_valid;
    logic signed [SCORE_W:0]   score_sum;
    logic [LEN_W:0]            len_sum;
    logic                      out_free;
    logic                      consume;

    assign out_free = !r_out_valid || !i_out_stall;
    assign consume  = i_step_valid && (!i_step.last || out_free);
    assign o_take   = !i_step_valid || consume;

    always_comb begin
        score_sum = (SCORE_W+1)'(r_score) + (SCORE_W+1)'(i_step.delta);
        if (score_sum[SCORE_W] != score_sum[SCORE_W-1]) begin
            n_score = score_sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end else begin
            n_score = score_sum[SCORE_W-1:0];
        end

        len_sum = {1'b0, r_len} + (LEN_W+1)'(i_step.len_inc);
        n_len   = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];

        n_match = r_match;
        n_mism  = r_mism;
        if (i_step.is_col) begin
            if (i_step.is_match) begin
                n_match = (r_match == '1) ? r_match : r_match + CNT_W'(1);
            end else begin
                n_mism = (r_mism == '1) ? r_mism : r_mism + CNT_W'(1);
            end
        end
        n_gap = r_gap;
        if (i_step.is_gap && r_gap != '1) begin
            n_gap = r_gap + GAP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score     <= '0;
            r_len       <= '0;
            r_match     <= '0;
            r_mism      <= '0;
            r_gap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (consume) begin
                if (i_step.last) begin
                    r_score <= '0;
                    r_len   <= '0;
                    r_match <= '0;
                    r_mism  <= '0;
                    r_gap   <= '0;
                end else begin
                    r_score <= n_score;
                    r_len   <= n_len;
                    r_match <= n_match;
                    r_mism  <= n_mism;
                    r_gap   <= n_gap;
                end
            end
            if (consume && i_step.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the totals including the closing word
    always_ff @(posedge i_clk) begin
        if (consume && i_step.last) begin
            o_score            <= n_score;
            o_alignment_length <= n_len;
            o_matches_res      <= n_match;
            o_mismatches       <= n_mism;
            o_gaps             <= n_gap;
        end
    end

    assign o_out_valid = r_out_valid;

    `CAS_ASSERT_NEXT(a_result_raised, consume && i_step.last, o_out_valid)
    `CAS_ASSERT_NOW(a_no_overwrite, r_out_valid && i_out_stall, !(consume && i_step.last))
    `CAS_ASSERT_NEXT(a_cleared_after_result, consume && i_step.last, r_len == '0 && r_gap == '0 && r_score == '0)
    `CAS_ASSERT_NOW(a_counts_fit_length, 1'b1, ({2'b00, r_match} + {2'b00, r_mism}) <= {1'b0, r_len})

endmodule

### sim/cas_totals_check.sv
// Checker for the alignment scoring unit: follows the configuration port, predicts the
// alignment totals for every accepted word and compares each result word against them.
// Depends on cas_pkg for widths, operation codes and register indexes.
module cas_totals_check import cas_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic [RUN_W-1:0]          i_run_length,
    input  logic [CODE_W-1:0]         i_query_code,
    input  logic [CODE_W-1:0]         i_target_code,
    input  logic                      i_last_item,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [SCORE_W-1:0] o_score,
    input  logic [LEN_W-1:0]          o_alignment_length,
    input  logic [CNT_W-1:0]          o_matches_res,
    input  logic [CNT_W-1:0]          o_mismatches,
    input  logic [GAP_W-1:0]          o_gaps,
    output int                        o_pending,
    output int                        o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SCORE_HI = (longint'(1) <<< (SCORE_W - 1)) - 1;
    localparam longint SCORE_LO = -SCORE_HI - 1;
    localparam logic [CFG_W-1:0] PEN_MASK = (48'd1 << PEN_W) - 1;

    typedef struct {
        longint score;
        longint length;
        longint hits;
        longint misses;
        longint gaps;
    } t_align_totals;

    // register copies
    logic signed [SUB_W-1:0] hit_pts;
    logic signed [SUB_W-1:0] miss_pts;
    logic                    n_as_miss;
    logic [CFG_W-1:0]        ins_open;
    logic [CFG_W-1:0]        del_open;
    logic [CFG_W-1:0]        ins_ext;
    logic [CFG_W-1:0]        del_ext;

    // running totals of the open alignment
    longint run_score;
    longint total_len;
    longint n_hits;
    longint n_misses;
    longint n_gaps;
    bit     at_left_end;

    t_align_totals totals_due[$];
    t_align_totals want;

    function automatic bit is_base(input logic [CODE_W-1:0] c);
        return c == CODE_A || c == CODE_C || c == CODE_G || c == CODE_T;
    endfunction

    function automatic longint sat_up(input longint v, input longint inc, input int width);
        longint top_val;
        top_val = (longint'(1) << width) - 1;
        return (v + inc > top_val) ? top_val : v + inc;
    endfunction

    task automatic add_points(input longint d);
        longint s;
        s = run_score + d;
        if (s > SCORE_HI) s = SCORE_HI;
        if (s < SCORE_LO) s = SCORE_LO;
        run_score = s;
    endtask

    task automatic clear_totals();
        run_score   = 0;
        total_len   = 0;
        n_hits      = 0;
        n_misses    = 0;
        n_gaps      = 0;
        at_left_end = 1'b1;
    endtask

    task automatic take_word(input logic [1:0] op, input logic [RUN_W-1:0] run_in,
                             input logic [CODE_W-1:0] qc, input logic [CODE_W-1:0] tc,
                             input logic last);
        longint        run;
        longint        delta;
        longint        pen_open;
        longint        pen_ext;
        int            shift;
        bit            n_hit;
        t_align_totals done;
        run = (longint'(run_in) > MAX_LEN) ? longint'(MAX_LEN) : longint'(run_in);
        if (op == OP_ALIGN) begin
            n_hit = n_as_miss && (qc == CODE_N || tc == CODE_N);
            delta = 0;
            if (n_hit) begin
                delta = miss_pts;
            end else if (is_base(qc) && is_base(tc)) begin
                delta = (qc == tc) ? hit_pts : miss_pts;
            end
            add_points(delta);
            // counting goes by code overlap, not by the score rule
            if (!n_hit && (qc & tc) != '0) n_hits = sat_up(n_hits, 1, CNT_W);
            else n_misses = sat_up(n_misses, 1, CNT_W);
            total_len = sat_up(total_len, 1, LEN_W);
            at_left_end = 1'b0;
        end else if (op == OP_INS || op == OP_DEL) begin
            // left end wins over right end
            shift = at_left_end ? 0 : (last ? 2 * PEN_W : PEN_W);
            pen_open = longint'(((op == OP_INS ? ins_open : del_open) >> shift) & PEN_MASK);
            pen_ext  = longint'(((op == OP_INS ? ins_ext : del_ext) >> shift) & PEN_MASK);
            add_points(-(pen_open + run * pen_ext));
            n_gaps = sat_up(n_gaps, 1, GAP_W);
            total_len = sat_up(total_len, run, LEN_W);
            if (run != 0) at_left_end = 1'b0;
        end
        if (last) begin
            done = '{run_score, total_len, n_hits, n_misses, n_gaps};
            totals_due.push_back(done);
            clear_totals();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns  totals check: %s", $time, what);
        o_errors++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint exp_v);
        if (got != exp_v) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_v));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_pts   = MATCH_SCORE_RST;
            miss_pts  = MISMATCH_SCORE_RST;
            n_as_miss = 1'b0;
            ins_open  = '0;
            del_open  = '0;
            ins_ext   = '0;
            del_ext   = '0;
            o_errors  = 0;
            clear_totals();
            totals_due.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (totals_due.size() == 0) begin
                    report_mismatch("result word with no alignment closed");
                end else begin
                    want = totals_due.pop_front();
                    compare_field("score", longint'(o_score), want.score);
                    compare_field("alignment_length", longint'(o_alignment_length),
                                  want.length);
                    compare_field("matches_res", longint'(o_matches_res), want.hits);
                    compare_field("mismatches", longint'(o_mismatches), want.misses);
                    compare_field("gaps", longint'(o_gaps), want.gaps);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MATCH_SCORE:    hit_pts   = i_cfg_data[SUB_W-1:0];
                    REG_MISMATCH_SCORE: miss_pts  = i_cfg_data[SUB_W-1:0];
                    REG_N_IS_MISMATCH:  n_as_miss = i_cfg_data[0];
                    REG_QUERY_OPEN:     ins_open  = i_cfg_data;
                    REG_TARGET_OPEN:    del_open  = i_cfg_data;
                    REG_QUERY_EXTEND:   ins_ext   = i_cfg_data;
                    REG_TARGET_EXTEND:  del_ext   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                take_word(i_op, i_run_length, i_query_code, i_target_code, i_last_item);
            end
        end
        o_pending <= totals_due.size();
    end

endmodule

### sim/testbench.sv
// Top of the alignment scoring unit regression: clock, reset, register setup, word stimulus.
// Depends on cas_pkg, cigar_alignment_scoring_unit and cas_totals_check.
module testbench;
    import cas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam logic [1:0]        OP_SPARE  = 2'd3;
    localparam logic [CODE_W-1:0] CODE_NONE = '0;
    localparam logic [CODE_W-1:0] CODE_AC   = CODE_A | CODE_C;
    localparam logic [CFG_W-1:0]  ALL_ONES  = '1;
    localparam logic [RUN_W-1:0]  RUN_TOP   = RUN_W'(RUN_MAX);
    localparam int                PHASES    = 8;
    localparam int                PHASE_LEN = 80;
    // maximal deletion runs at full penalty for a deeply negative score
    localparam int                DEEP_RUNS = 12;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [1:0]                i_op;
    logic [RUN_W-1:0]          i_run_length;
    logic [CODE_W-1:0]         i_query_code;
    logic [CODE_W-1:0]         i_target_code;
    logic                      i_last_item;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [SCORE_W-1:0] o_score;
    logic [LEN_W-1:0]          o_alignment_length;
    logic [CNT_W-1:0]          o_matches_res;
    logic [CNT_W-1:0]          o_mismatches;
    logic [GAP_W-1:0]          o_gaps;

    int pending_totals;
    int error_total;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [CFG_W-1:0] reg_val [REG_TARGET_EXTEND+1];

    cigar_alignment_scoring_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_run_length       (i_run_length),
        .i_query_code       (i_query_code),
        .i_target_code      (i_target_code),
        .i_last_item        (i_last_item),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_score            (o_score),
        .o_alignment_length (o_alignment_length),
        .o_matches_res      (o_matches_res),
        .o_mismatches       (o_mismatches),
        .o_gaps             (o_gaps)
    );

    cas_totals_check u_totals_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_run_length       (i_run_length),
        .i_query_code       (i_query_code),
        .i_target_code      (i_target_code),
        .i_last_item        (i_last_item),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_score            (o_score),
        .o_alignment_length (o_alignment_length),
        .o_matches_res      (o_matches_res),
        .o_mismatches       (o_mismatches),
        .o_gaps             (o_gaps),
        .o_pending          (pending_totals),
        .o_errors           (error_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #2_000_000;
        $display("cigar_alignment_scoring_unit regression: fail");
        $finish;
    end

    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 17 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 17 : 0;
    endtask

    // Returns at the edge that takes the word; valid stays up for a following word.
    task automatic send_word(input logic [1:0] op, input logic [RUN_W-1:0] run,
                             input logic [CODE_W-1:0] qc, input logic [CODE_W-1:0] tc,
                             input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_run_length  <= run;
        i_query_code  <= qc;
        i_target_code <= tc;
        i_last_item   <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid, then hold until every closed alignment has been reported.
    task automatic wait_for_totals();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_totals != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] hit, input logic [CFG_W-1:0] miss,
                            input logic [CFG_W-1:0] n_rule,
                            input logic [CFG_W-1:0] q_open, input logic [CFG_W-1:0] t_open,
                            input logic [CFG_W-1:0] q_ext, input logic [CFG_W-1:0] t_ext);
        reg_val[REG_MATCH_SCORE]    = hit;
        reg_val[REG_MISMATCH_SCORE] = miss;
        reg_val[REG_N_IS_MISMATCH]  = n_rule;
        reg_val[REG_QUERY_OPEN]     = q_open;
        reg_val[REG_TARGET_OPEN]    = t_open;
        reg_val[REG_QUERY_EXTEND]   = q_ext;
        reg_val[REG_TARGET_EXTEND]  = t_ext;
        for (int k = 0; k <= REG_TARGET_EXTEND; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(k);
            i_cfg_data <= reg_val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand_penalties();
        logic [CFG_W-1:0] p;
        p = CFG_W'({$urandom, $urandom});
        // small penalties most of the time so scores stay readable
        return $urandom_range(2) == 0 ? p : p & 48'h00FF_00FF_00FF;
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        int pick;
        pick = $urandom_range(19);
        if (pick < 12) return CODE_A << $urandom_range(3);
        if (pick < 15) return CODE_N;
        return CODE_W'($urandom_range(15));
    endfunction

    task automatic send_random_word(input logic last);
        logic [1:0]       op;
        logic [RUN_W-1:0] run;
        int               pick;
        pick = $urandom_range(99);
        op = pick < 64 ? OP_ALIGN : pick < 80 ? OP_INS : pick < 96 ? OP_DEL : OP_SPARE;
        pick = $urandom_range(9);
        run = pick < 6 ? RUN_W'($urandom_range(8, 1)) : pick == 6 ? '0 :
              pick == 7 ? RUN_W'($urandom_range(64)) : RUN_W'($urandom_range(RUN_MAX));
        send_word(op, run, rand_code(), rand_code(), last);
    endtask

    task automatic random_phase(input t_idle_mode mode, input int n_words);
        logic last;
        set_idling(mode);
        for (int n = 0; n < n_words; n++) begin
            last = ($urandom_range(9) == 0) || (n == n_words - 1);
            send_random_word(last);
            // now and then hold off until the scorer has caught up
            if (last && $urandom_range(5) == 0) wait_for_totals();
        end
        wait_for_totals();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_MATCH_SCORE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_op          = OP_ALIGN;
        i_run_length  = '0;
        i_query_code  = CODE_NONE;
        i_target_code = CODE_NONE;
        i_last_item   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: N rule off, gaps free
        set_idling(IDLE_NONE);
        send_word(OP_DEL, 0, CODE_NONE, CODE_NONE, 1'b0);
        send_word(OP_ALIGN, 0, CODE_A, CODE_A, 1'b0);
        send_word(OP_ALIGN, 0, CODE_C, CODE_G, 1'b0);
        send_word(OP_ALIGN, 0, CODE_N, CODE_N, 1'b0);
        send_word(OP_ALIGN, 0, CODE_N, CODE_T, 1'b0);
        send_word(OP_ALIGN, 0, CODE_NONE, CODE_NONE, 1'b0);
        send_word(OP_ALIGN, 0, CODE_AC, CODE_C, 1'b0);
        send_word(OP_INS, 5, CODE_G, CODE_T, 1'b1);
        wait_for_totals();

        set_regs(5, -3, 1, {16'd30, 16'd20, 16'd10}, {16'd33, 16'd22, 16'd11},
                 {16'd3, 16'd2, 16'd1}, {16'd6, 16'd5, 16'd4});
        // zero-length gap keeps the left end open
        send_word(OP_DEL, 0, CODE_A, CODE_C, 1'b0);
        send_word(OP_INS, 3, CODE_A, CODE_C, 1'b0);
        send_word(OP_ALIGN, 0, CODE_A, CODE_A, 1'b0);
        send_word(OP_ALIGN, 0, CODE_A, CODE_C, 1'b0);
        send_word(OP_ALIGN, 0, CODE_N, CODE_A, 1'b0);
        send_word(OP_ALIGN, 0, CODE_AC, CODE_A, 1'b0);
        send_word(OP_DEL, RUN_TOP, CODE_T, CODE_G, 1'b0);
        send_word(OP_INS, 1, CODE_G, CODE_T, 1'b0);
        send_word(OP_SPARE, RUN_TOP, CODE_N, CODE_N, 1'b0);
        send_word(OP_DEL, 2, CODE_C, CODE_A, 1'b1);
        // empty alignment closed by an unused op
        send_word(OP_SPARE, 0, CODE_NONE, CODE_NONE, 1'b1);
        // lone gap on the closing word counts as left end
        send_word(OP_INS, 7, CODE_A, CODE_A, 1'b1);
        send_word(OP_ALIGN, 0, CODE_T, CODE_T, 1'b1);
        // four clamped runs overflow the length total
        repeat (3) send_word(OP_INS, RUN_TOP, CODE_A, CODE_A, 1'b0);
        send_word(OP_DEL, RUN_TOP, CODE_A, CODE_A, 1'b1);
        wait_for_totals();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: set_regs(255, -255, 1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
                4: set_regs(-255, 255, 0, '0, '0, '0, '0);
                default: set_regs($urandom_range(510) - 255, $urandom_range(510) - 255,
                                  $urandom_range(1), rand_penalties(), rand_penalties(),
                                  rand_penalties(), rand_penalties());
            endcase
            random_phase(t_idle_mode'(p % 4), PHASE_LEN);
        end

        // drive the score deep below zero with maximal runs, then step back up
        set_idling(IDLE_NONE);
        set_regs(255, -255, 0, '0, ALL_ONES, '0, ALL_ONES);
        repeat (DEEP_RUNS) send_word(OP_DEL, RUN_TOP, CODE_A, CODE_A, 1'b0);
        repeat (3) send_word(OP_ALIGN, 0, CODE_G, CODE_G, 1'b0);
        send_word(OP_DEL, 1, CODE_A, CODE_A, 1'b1);
        wait_for_totals();
        repeat (8) @(posedge i_clk);

        if (error_total == 0) begin
            $display("cigar_alignment_scoring_unit regression: pass");
        end else begin
            $display("cigar_alignment_scoring_unit regression: fail");
        end
        $finish;
    end

endmodule
